@@ design/gcb_pkg.sv @@
`default_nettype none

package gcb_pkg;

    // Width of the point index within a contour, and its saturation value.
    localparam int IDX_BITS = 16;
    localparam logic [IDX_BITS-1:0] IDX_MAX = '1;

    // One accepted point causes at most three segments.
    localparam int NUM_SLOTS = 3;
    localparam int SLOT_BITS = 2;

    // Slot positions within a job.
    localparam logic [SLOT_BITS-1:0] SLOT_OWN    = 2'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_FIRST  = 2'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_SECOND = 2'd2;

    // Queue depth between the front and the back.
    localparam int Q_DEPTH = 4;

    // Segment kinds.
    localparam logic SEG_LINEAR    = 1'b0;
    localparam logic SEG_QUADRATIC = 1'b1;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

@@ design/glyph_contour_to_bezier_segments.sv @@
// Outline point to segment converter.
// Input channel: i_valid / o_stall with one outline point per transaction
// (i_x, i_y, i_on_curve, i_contour_end). Output channel: o_valid / i_stall
// with one line or quadratic segment per transaction; coordinates are doubled,
// o_point_index names the point that closes the segment and o_last_of_run
// marks the final segment caused by an input point.
// An accepted point enters the job queue; the segment builder then loads its
// first segment into the output register. Throughput while i_stall is low:
// one point per cycle while each point gives at most one segment; a contour
// end point gives up to three segments, which leave one per cycle through the
// single output register. A point with no segment shows nothing at the output.
// A four-entry job queue sits between the classifier and the segment
// builder, so the input keeps flowing while the output is stalled until the
// queue fills; o_stall is the queue's full flag.
// Reset (synchronous, active low) clears the contour history, empties the
// queue and drops any pending output. While i_stall is high the presented
// segment holds steady.
`default_nettype none

module glyph_contour_to_bezier_segments
    import gcb_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic                         i_on_curve,
    input  wire logic                         i_contour_end,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_seg_kind,
    output logic signed [COORD_BITS:0]        o_p0_x2,
    output logic signed [COORD_BITS:0]        o_p0_y2,
    output logic signed [COORD_BITS:0]        o_p1_x2,
    output logic signed [COORD_BITS:0]        o_p1_y2,
    output logic signed [COORD_BITS:0]        o_p2_x2,
    output logic signed [COORD_BITS:0]        o_p2_y2,
    output logic [IDX_BITS-1:0]               o_point_index,
    output logic                              o_last_of_run
);

    localparam int PT_W  = 2 * COORD_BITS + 1;
    localparam int JOB_W = NUM_SLOTS * 3 * PT_W + IDX_BITS + NUM_SLOTS;

    logic             w_accept;
    logic             w_push;
    logic             w_pop;
    logic [JOB_W-1:0] w_job_in;
    logic [JOB_W-1:0] w_job_out;
    t_q_status        w_q_status;

    assign o_stall  = w_q_status.full;
    assign w_accept = i_valid && !w_q_status.full;

    // Classifier with the contour history.
    gcb_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_on_curve    (i_on_curve),
        .i_contour_end (i_contour_end),
        .o_push        (w_push),
        .o_job         (w_job_in)
    );

    // Job queue between classifier and segment builder.
    gcb_queue #(
        .WIDTH(JOB_W),
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_job_in),
        .i_pop    (w_pop),
        .o_data   (w_job_out),
        .o_status (w_q_status)
    );

    // Segment builder and output register.
    gcb_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_job_out),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_seg_kind    (o_seg_kind),
        .o_p0_x2       (o_p0_x2),
        .o_p0_y2       (o_p0_y2),
        .o_p1_x2       (o_p1_x2),
        .o_p1_y2       (o_p1_y2),
        .o_p2_x2       (o_p2_x2),
        .o_p2_y2       (o_p2_y2),
        .o_point_index (o_point_index),
        .o_last_of_run (o_last_of_run)
    );

    // A job is only retired while the queue holds one.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("job retired from an empty queue");

    // The queue cannot report full and empty at once.
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue status inconsistent");

    // A line segment carries no quadratic end point.
    a_linear_p2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_seg_kind == SEG_LINEAR) |-> (o_p2_x2 == '0 && o_p2_y2 == '0))
        else $error("linear segment with nonzero end point");

    // Segments of one point leave back to back once the receiver takes them.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run && !i_stall) |=> o_valid)
        else $error("gap inside the segments of one point");

endmodule

`default_nettype wire

@@ design/gcb_front.sv @@
`default_nettype none

module gcb_front
    import gcb_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int PT_W  = 2 * COORD_BITS + 1,
    localparam int JOB_W = NUM_SLOTS * 3 * PT_W + IDX_BITS + NUM_SLOTS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic                         i_on_curve,
    input  wire logic                         i_contour_end,
    output logic                              o_push,
    output logic [JOB_W-1:0]                  o_job
);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         on;
    } t_point;

    typedef struct packed {
        t_point c;
        t_point p;
        t_point q;
    } t_req;

    typedef struct packed {
        t_req [NUM_SLOTS-1:0]  req;
        logic [IDX_BITS-1:0]   idx;
        logic [NUM_SLOTS-1:0]  mask;
    } t_job;

    t_point              r_first, r_second, r_prev, r_prev2;
    t_point              n_first, n_second, n_prev, n_prev2;
    logic [IDX_BITS-1:0] r_count, n_count;

    t_point              w_cur;
    t_job                w_job;
    logic [NUM_SLOTS-1:0] w_slot_on;

    assign w_cur = '{x: i_x, y: i_y, on: i_on_curve};

    // Classify the point: pick the point triples of every segment it closes.
    always_comb begin
        w_job     = '0;
        w_slot_on = '0;
        w_job.idx = r_count;
        if (r_count == '0) begin
            w_job.req[SLOT_OWN] = '{c: w_cur, p: w_cur, q: w_cur};
            w_slot_on[SLOT_OWN] = i_contour_end;
        end else if (r_count == IDX_BITS'(1)) begin
            w_job.req[SLOT_OWN]   = '{c: w_cur, p: r_first, q: w_cur};
            w_job.req[SLOT_FIRST] = '{c: r_first, p: w_cur, q: r_first};
            w_slot_on[SLOT_OWN]   = i_contour_end;
            w_slot_on[SLOT_FIRST] = i_contour_end;
        end else begin
            w_job.req[SLOT_OWN]    = '{c: w_cur, p: r_prev, q: r_prev2};
            w_job.req[SLOT_FIRST]  = '{c: r_first, p: w_cur, q: r_prev};
            w_job.req[SLOT_SECOND] = '{c: r_second, p: r_first, q: w_cur};
            w_slot_on[SLOT_OWN]    = 1'b1;
            w_slot_on[SLOT_FIRST]  = i_contour_end;
            w_slot_on[SLOT_SECOND] = i_contour_end;
        end
        // An on point followed by an off point closes no segment.
        for (int s = 0; s < NUM_SLOTS; s++) begin
            w_job.mask[s] = w_slot_on[s] &&
                            !(w_job.req[s].p.on && !w_job.req[s].c.on);
        end
    end

    assign o_job  = JOB_W'(w_job);
    assign o_push = i_accept && (w_job.mask != '0);

    // Contour history update on every accepted point.
    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_prev   = r_prev;
        n_prev2  = r_prev2;
        n_count  = r_count;
        if (i_accept) begin
            if (r_count == '0) begin
                n_first = w_cur;
            end
            if (r_count == IDX_BITS'(1)) begin
                n_second = w_cur;
            end
            n_prev2 = r_prev;
            n_prev  = w_cur;
            if (i_contour_end) begin
                n_count = '0;
            end else if (r_count != IDX_MAX) begin
                n_count = r_count + IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_prev   <= '0;
            r_prev2  <= '0;
            r_count  <= '0;
        end else begin
            r_first  <= n_first;
            r_second <= n_second;
            r_prev   <= n_prev;
            r_prev2  <= n_prev2;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ design/gcb_queue.sv @@
`default_nettype none

module gcb_queue
    import gcb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output t_q_status             o_status
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign w_do_push = i_push && (r_count != CNT_W'(DEPTH));
    assign w_do_pop  = i_pop && (r_count != '0);

    // Pointer and fill count bookkeeping.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

@@ design/gcb_back.sv @@
`default_nettype none

module gcb_back
    import gcb_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int PT_W  = 2 * COORD_BITS + 1,
    localparam int OUT_W = COORD_BITS + 1,
    localparam int JOB_W = NUM_SLOTS * 3 * PT_W + IDX_BITS + NUM_SLOTS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [JOB_W-1:0]        i_job,
    input  wire t_q_status               i_q_status,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic                         o_seg_kind,
    output logic signed [OUT_W-1:0]      o_p0_x2,
    output logic signed [OUT_W-1:0]      o_p0_y2,
    output logic signed [OUT_W-1:0]      o_p1_x2,
    output logic signed [OUT_W-1:0]      o_p1_y2,
    output logic signed [OUT_W-1:0]      o_p2_x2,
    output logic signed [OUT_W-1:0]      o_p2_y2,
    output logic [IDX_BITS-1:0]          o_point_index,
    output logic                         o_last_of_run
);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         on;
    } t_point;

    typedef struct packed {
        t_point c;
        t_point p;
        t_point q;
    } t_req;

    typedef struct packed {
        t_req [NUM_SLOTS-1:0]  req;
        logic [IDX_BITS-1:0]   idx;
        logic [NUM_SLOTS-1:0]  mask;
    } t_job;

    // Doubled coordinate and sum of two coordinates, both exact in OUT_W bits.
    function automatic logic [OUT_W-1:0] dbl(input logic [COORD_BITS-1:0] a);
        return {a, 1'b0};
    endfunction

    function automatic logic [OUT_W-1:0] add2(input logic [COORD_BITS-1:0] a,
                                              input logic [COORD_BITS-1:0] b);
        return {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    endfunction

    t_job                 w_job;
    t_req                 w_req;
    logic [NUM_SLOTS-1:0] w_left, w_sel_bit;
    logic [SLOT_BITS-1:0] w_sel;
    logic                 w_last, w_advance;

    logic                 r_valid, n_valid;
    logic [NUM_SLOTS-1:0] r_done, n_done;
    logic                 r_kind;
    logic [OUT_W-1:0]     r_p0x, r_p0y, r_p1x, r_p1y, r_p2x, r_p2y;
    logic [OUT_W-1:0]     w_p0x, w_p0y, w_p1x, w_p1y, w_p2x, w_p2y;
    logic [IDX_BITS-1:0]  r_idx, w_idx;
    logic                 r_last;

    assign w_job  = t_job'(i_job);
    assign w_left = w_job.mask & ~r_done;

    // Lowest pending slot of the job at the head of the queue.
    always_comb begin
        if (w_left[SLOT_OWN]) begin
            w_sel = SLOT_OWN;
        end else if (w_left[SLOT_FIRST]) begin
            w_sel = SLOT_FIRST;
        end else begin
            w_sel = SLOT_SECOND;
        end
    end

    assign w_sel_bit = NUM_SLOTS'(1) << w_sel;
    assign w_last    = (w_left & ~w_sel_bit) == '0;
    assign w_req     = w_job.req[w_sel];
    assign w_advance = !i_q_status.empty && (!r_valid || !i_stall);
    assign o_pop     = w_advance && w_last;

    // Segment geometry for the selected slot.
    always_comb begin
        w_p2x = '0;
        w_p2y = '0;
        if (w_req.p.on) begin
            w_p0x = dbl(w_req.p.x);
            w_p0y = dbl(w_req.p.y);
            w_p1x = dbl(w_req.c.x);
            w_p1y = dbl(w_req.c.y);
        end else begin
            w_p0x = w_req.q.on ? dbl(w_req.q.x) : add2(w_req.p.x, w_req.q.x);
            w_p0y = w_req.q.on ? dbl(w_req.q.y) : add2(w_req.p.y, w_req.q.y);
            w_p1x = dbl(w_req.p.x);
            w_p1y = dbl(w_req.p.y);
            w_p2x = w_req.c.on ? dbl(w_req.c.x) : add2(w_req.c.x, w_req.p.x);
            w_p2y = w_req.c.on ? dbl(w_req.c.y) : add2(w_req.c.y, w_req.p.y);
        end
        case (w_sel)
            SLOT_OWN:    w_idx = w_job.idx;
            SLOT_FIRST:  w_idx = '0;
            default:     w_idx = IDX_BITS'(1);
        endcase
    end

    // Output register and slot progress.
    always_comb begin
        n_valid = r_valid;
        n_done  = r_done;
        if (w_advance) begin
            n_valid = 1'b1;
            n_done  = w_last ? '0 : (r_done | w_sel_bit);
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            r_valid <= n_valid;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_kind <= w_req.p.on ? SEG_LINEAR : SEG_QUADRATIC;
            r_p0x  <= w_p0x;
            r_p0y  <= w_p0y;
            r_p1x  <= w_p1x;
            r_p1y  <= w_p1y;
            r_p2x  <= w_p2x;
            r_p2y  <= w_p2y;
            r_idx  <= w_idx;
            r_last <= w_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_seg_kind    = r_kind;
    assign o_p0_x2       = r_p0x;
    assign o_p0_y2       = r_p0y;
    assign o_p1_x2       = r_p1x;
    assign o_p1_y2       = r_p1y;
    assign o_p2_x2       = r_p2x;
    assign o_p2_y2       = r_p2y;
    assign o_point_index = r_idx;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire
